// ===== hdl/gzb_pkg.sv =====
package gzb_pkg;

  // grid geometry
  localparam int GRID_COLS   = 4;
  localparam int GRID_ROWS   = 4;
  localparam int MAX_PLANES  = 256;
  localparam int ZONE_COUNT  = GRID_COLS * GRID_ROWS;
  localparam int MAX_RESULTS = 16;

  localparam int ZONE_W    = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int PLANE_W   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int FILL_W    = $clog2(MAX_PLANES + 1);
  localparam int MEM_DEPTH = ZONE_COUNT * MAX_PLANES;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int SCR_W     = 12;
  localparam int ID_W      = 8;
  localparam int POS_W     = 13;
  localparam int SIZE_W    = 9;
  localparam int COORD_W   = 14;
  localparam int ZIDX_W    = 4;
  localparam int SLOT_W    = 8;

  // zone size by reciprocal multiply: estimate is exact or one short
  localparam int DIV_SHIFT  = 16;
  localparam int RECIP_W    = DIV_SHIFT + 1;
  localparam int PROD_W     = SCR_W + RECIP_W;
  localparam int COLS_RECIP = (1 << DIV_SHIFT) / GRID_COLS;
  localparam int ROWS_RECIP = (1 << DIV_SHIFT) / GRID_ROWS;
  localparam int REM_W      = SCR_W + 5;

  localparam logic [SCR_W-1:0] SCR_W_RESET = SCR_W'(800);
  localparam logic [SCR_W-1:0] SCR_H_RESET = SCR_W'(600);

  // register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  // item kinds
  localparam logic OP_CLEAR  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                     op;
    logic [ID_W-1:0]          plane_id;
    logic signed [POS_W-1:0]  plane_left;
    logic signed [POS_W-1:0]  plane_top;
    logic [SIZE_W-1:0]        plane_width;
    logic [SIZE_W-1:0]        plane_height;
  } item_t;

  typedef struct packed {
    logic load;
    logic size_est;
    logic size_fix;
    logic mask;
    logic walk;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } sts_t;

  function automatic logic in_span(coord_t a, coord_t b, coord_t lo, coord_t hi);
    return ((a >= lo) && (a <= hi)) || ((b >= lo) && (b <= hi));
  endfunction

endpackage

// ===== hdl/grid_zone_binning.sv =====
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+---------------------------------------------
// in_      | in  | in_tvalid/in_tready  | tuser: op; tdata: id, left, top, width, height
// out_     | out | out_tvalid/out_tready| tuser: hit, overflow; tdata: zone, slot; tlast
// cfg_     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (screen width / height)
//
// an item goes through setup steps (zone size estimate, correction, zone mask), then a
// walk of one hit zone per cycle while results are taken, at least one: a clear or a miss
// gives one empty result. a hit zone with room gets one fill counter update and one store write.
// reset gives an 800 by 600 field and empty zone lists; the member store is not cleared.
// the walk pauses while the output register holds a result that is not taken.
module grid_zone_binning (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [55:0]                    in_tdata,   // plane_id, plane_left, plane_top,
                                                     // plane_width, plane_height, zero pad
  input  logic                           in_tuser,   // op
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // zone_index, slot, zero pad
  output logic [1:0]                     out_tuser,  // hit, overflow
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gzb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gzb_pkg::SCR_W-1:0]      cfg_data
);
  import gzb_pkg::*;

  item_t             item;
  cmd_t              cmd;
  sts_t              sts;
  logic [ZIDX_W-1:0] zone;
  logic [SLOT_W-1:0] slot;
  logic              hit, ovf;

  assign cfg_ready = 1'b1;

  assign item.op           = in_tuser;
  assign item.plane_id     = in_tdata[7:0];
  assign item.plane_left   = in_tdata[20:8];
  assign item.plane_top    = in_tdata[33:21];
  assign item.plane_width  = in_tdata[42:34];
  assign item.plane_height = in_tdata[51:43];

  gzb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gzb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_zone  (zone),
    .out_slot  (slot),
    .out_hit   (hit),
    .out_ovf   (ovf),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'b0000, slot, zone};
  assign out_tuser = {ovf, hit};

endmodule

// ===== hdl/gzb_ctrl.sv =====
module gzb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output gzb_pkg::cmd_t cmd,
  input  gzb_pkg::sts_t sts
);
  import gzb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EST  = 5'b00010,
    ST_FIX  = 5'b00100,
    ST_MASK = 5'b01000,
    ST_WALK = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EST;
      ST_EST:  state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_MASK;
      ST_MASK: state_nxt = ST_WALK;
      ST_WALK: if (sts.walk_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = in_tvalid && (state_r == ST_IDLE);
    cmd.size_est = (state_r == ST_EST);
    cmd.size_fix = (state_r == ST_FIX);
    cmd.mask     = (state_r == ST_MASK);
    cmd.walk     = (state_r == ST_WALK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    sts.walk_done |-> state_r == ST_WALK)
    else $error("walk finished outside the walk state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_EST)
    else $error("accepted item did not start the sizing step");

  a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && sts.walk_done) |=> in_tready)
    else $error("input not reopened after the last zone");

endmodule

// ===== hdl/gzb_datapath.sv =====
module gzb_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr,
  input  logic [gzb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gzb_pkg::SCR_W-1:0]         cfg_data,
  input  gzb_pkg::item_t                    item,
  input  gzb_pkg::cmd_t                     cmd,
  output gzb_pkg::sts_t                     sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [gzb_pkg::ZIDX_W-1:0]        out_zone,
  output logic [gzb_pkg::SLOT_W-1:0]        out_slot,
  output logic                              out_hit,
  output logic                              out_ovf,
  output logic                              out_last
);
  import gzb_pkg::*;

  logic [SCR_W-1:0]      scr_w_r, scr_h_r;
  logic                  op_r;
  logic [ID_W-1:0]       id_r;
  coord_t                x0_r, x1_r, y0_r, y1_r;
  logic [SCR_W-1:0]      zw_est_r, zh_est_r, zw_r, zh_r;
  logic [ZONE_COUNT-1:0] pend_r;
  logic [RES_CNT_W-1:0]  cnt_r;
  logic [FILL_W-1:0]     fill_r [ZONE_COUNT];
  logic [ID_W-1:0]       members [MEM_DEPTH];

  logic                  out_valid_r;
  logic [ZIDX_W-1:0]     out_zone_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic                  out_hit_r, out_ovf_r, out_last_r;

  logic [PROD_W-1:0]     w_prod, h_prod;
  logic [REM_W-1:0]      w_rem, h_rem;
  logic [GRID_COLS-1:0]  col_hit;
  logic [GRID_ROWS-1:0]  row_hit;
  logic [ZONE_COUNT-1:0] zmask;
  coord_t                lo, hi;

  logic [ZONE_W-1:0]     cur_z;
  logic [ZONE_COUNT-1:0] cur_oh, rest;
  logic                  any, full, step, report, last_c, done;
  logic [FILL_W-1:0]     fill_cur;
  logic [MEM_AW-1:0]     mem_addr;

  // zone size estimate, then one correction
  assign w_prod = PROD_W'(scr_w_r) * PROD_W'(COLS_RECIP);
  assign h_prod = PROD_W'(scr_h_r) * PROD_W'(ROWS_RECIP);
  assign w_rem  = REM_W'(scr_w_r) - REM_W'(zw_est_r) * REM_W'(GRID_COLS);
  assign h_rem  = REM_W'(scr_h_r) - REM_W'(zh_est_r) * REM_W'(GRID_ROWS);

  // one lane per column and per row, bounds inclusive on both sides
  always_comb begin
    col_hit = '0;
    row_hit = '0;
    lo      = '0;
    hi      = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      lo = COORD_W'(SCR_W'(SCR_W'(c) * zw_r));
      hi = lo + COORD_W'(zw_r);
      col_hit[c] = in_span(x0_r, x1_r, lo, hi);
    end
    for (int r = 0; r < GRID_ROWS; r++) begin
      lo = COORD_W'(SCR_W'(SCR_W'(r) * zh_r));
      hi = lo + COORD_W'(zh_r);
      row_hit[r] = in_span(y0_r, y1_r, lo, hi);
    end
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        zmask[r*GRID_COLS + c] = row_hit[r] && col_hit[c] && (op_r == OP_INSERT);
      end
    end
  end

  // lowest pending zone first, so results come in zone order
  always_comb begin
    cur_z = '0;
    for (int i = ZONE_COUNT - 1; i >= 0; i--) begin
      if (pend_r[i]) cur_z = ZONE_W'(i);
    end
  end

  assign cur_oh   = ZONE_COUNT'(1) << cur_z;
  assign rest     = pend_r & ~cur_oh;
  assign any      = |pend_r;
  assign fill_cur = fill_r[cur_z];
  assign full     = fill_cur >= FILL_W'(MAX_PLANES);
  assign step     = cmd.walk && (!out_valid_r || out_ready);
  assign report   = cnt_r < RES_CNT_W'(MAX_RESULTS);
  assign last_c   = !any || (rest == '0) || (cnt_r == RES_CNT_W'(MAX_RESULTS - 1));
  assign done     = step && (!any || (rest == '0));
  assign mem_addr = MEM_AW'(cur_z) * MEM_AW'(MAX_PLANES) + MEM_AW'(fill_cur);

  assign sts.walk_done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCR_W_RESET;
      scr_h_r <= SCR_H_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= item.op;
      id_r <= item.plane_id;
      x0_r <= COORD_W'(item.plane_left);
      y0_r <= COORD_W'(item.plane_top);
      x1_r <= COORD_W'(item.plane_left) + COORD_W'(item.plane_width);
      y1_r <= COORD_W'(item.plane_top) + COORD_W'(item.plane_height);
    end
    if (cmd.size_est) begin
      zw_est_r <= SCR_W'(w_prod >> DIV_SHIFT);
      zh_est_r <= SCR_W'(h_prod >> DIV_SHIFT);
    end
    if (cmd.size_fix) begin
      zw_r <= (w_rem >= REM_W'(GRID_COLS)) ? zw_est_r + 1'b1 : zw_est_r;
      zh_r <= (h_rem >= REM_W'(GRID_ROWS)) ? zh_est_r + 1'b1 : zh_est_r;
    end
    if (step && report) begin
      out_zone_r <= any ? ZIDX_W'(cur_z) : '0;
      out_slot_r <= (any && !full) ? SLOT_W'(fill_cur) : '0;
      out_hit_r  <= any;
      out_ovf_r  <= any && full;
      out_last_r <= last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ZONE_COUNT; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      out_valid_r <= (out_valid_r && !out_ready) || (step && report);
      if (cmd.mask) begin
        pend_r <= zmask;
        cnt_r  <= '0;
      end else if (step) begin
        pend_r <= rest;
        if (report) cnt_r <= cnt_r + 1'b1;
        if (!any && (op_r == OP_CLEAR)) begin
          for (int i = 0; i < ZONE_COUNT; i++) begin
            fill_r[i] <= '0;
          end
        end else if (any && !full) begin
          fill_r[cur_z] <= fill_cur + 1'b1;
        end
      end
    end
  end

  // member store: append only
  always_ff @(posedge clk) begin
    if (step && any && !full) begin
      members[mem_addr] <= id_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_zone  = out_zone_r;
  assign out_slot  = out_slot_r;
  assign out_hit   = out_hit_r;
  assign out_ovf   = out_ovf_r;
  assign out_last  = out_last_r;

  a_empty_only_first: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !any) |-> cnt_r == '0)
    else $error("empty zone set seen after results were sent");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count past its limit");

  a_report_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (step && report) |=> out_valid_r)
    else $error("reported zone did not reach the output register");

endmodule

// ===== tb/tb.sv =====
module tb;
  import gzb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 300;

  typedef struct packed {
    logic [ZIDX_W-1:0] zone;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              ovf;
    logic              last;
  } zone_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [55:0]          in_tdata = '0;   // plane_id, plane_left, plane_top,
                                         // plane_width, plane_height, zero pad
  logic                 in_tuser = 1'b0; // op
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;       // zone_index, slot, zero pad
  logic [1:0]           out_tuser;       // hit, overflow
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCR_W-1:0]     cfg_data = '0;

  grid_zone_binning dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // local copy of the block's state
  logic [SCR_W-1:0]  field_w = SCR_W_RESET;
  logic [SCR_W-1:0]  field_h = SCR_W_RESET == 0 ? '0 : SCR_H_RESET;
  logic [FILL_W-1:0] zone_fill_model [ZONE_COUNT];

  item_t        pending_items [$];
  zone_report_t zone_reports_due [$];
  item_t        on_offer;
  zone_report_t taken_report;

  int   items_queued = 0;
  int   items_taken = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   stall_left = 0;
  int   cycle_count = 0;
  logic calm = 1'b0;
  logic stall_req = 1'b0;
  logic stall_taken = 1'b0;
  logic failed = 1'b0;

  initial begin
    foreach (zone_fill_model[z]) zone_fill_model[z] = '0;
  end

  // works out the zone reports that one accepted item causes
  function automatic void bin_plane(item_t it);
    int x0, y0, x1, y1, zw, zh, top, left, z;
    zone_report_t found [$];
    zone_report_t rep;
    if (it.op == OP_CLEAR) begin
      foreach (zone_fill_model[k]) zone_fill_model[k] = '0;
      zone_reports_due.push_back('{zone: '0, slot: '0, hit: 1'b0, ovf: 1'b0, last: 1'b1});
      return;
    end
    x0 = $signed(it.plane_left);
    y0 = $signed(it.plane_top);
    x1 = x0 + int'(it.plane_width);
    y1 = y0 + int'(it.plane_height);
    zw = int'(field_w) / GRID_COLS;
    zh = int'(field_h) / GRID_ROWS;
    for (int r = 0; r < GRID_ROWS; r++) begin
      top = r * zh;
      if (!((y0 >= top && y0 <= top + zh) || (y1 >= top && y1 <= top + zh))) continue;
      for (int c = 0; c < GRID_COLS; c++) begin
        left = c * zw;
        if (!((x0 >= left && x0 <= left + zw) || (x1 >= left && x1 <= left + zw))) continue;
        z = r * GRID_COLS + c;
        rep.zone = ZIDX_W'(z);
        rep.hit  = 1'b1;
        rep.last = 1'b0;
        if (zone_fill_model[z] < MAX_PLANES) begin
          rep.slot = SLOT_W'(zone_fill_model[z]);
          rep.ovf  = 1'b0;
          zone_fill_model[z] = zone_fill_model[z] + 1'b1;
        end else begin
          // zone list full, the id is dropped
          rep.slot = '0;
          rep.ovf  = 1'b1;
        end
        if (found.size() < MAX_RESULTS) found.push_back(rep);
      end
    end
    if (found.size() == 0) begin
      zone_reports_due.push_back('{zone: '0, slot: '0, hit: 1'b0, ovf: 1'b0, last: 1'b1});
      return;
    end
    found[found.size() - 1].last = 1'b1;
    foreach (found[k]) zone_reports_due.push_back(found[k]);
  endfunction

  function automatic item_t make_insert(logic [ID_W-1:0] id, int left, int top, int w, int h);
    item_t it;
    it.op           = OP_INSERT;
    it.plane_id     = id;
    it.plane_left   = POS_W'(left);
    it.plane_top    = POS_W'(top);
    it.plane_width  = SIZE_W'(w);
    it.plane_height = SIZE_W'(h);
    return it;
  endfunction

  // a clear carries random payload bits that the block must ignore
  function automatic item_t make_clear();
    item_t it;
    it = make_insert(ID_W'($urandom), $urandom, $urandom, $urandom, $urandom);
    it.op = OP_CLEAR;
    return it;
  endfunction

  function automatic item_t random_plane();
    return make_insert(ID_W'($urandom), $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      failed = 1'b1;
    end
  endfunction

  // driver: offers queued items, predicts on each accepted transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        bin_plane(on_offer);
        items_taken = items_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap    <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0 && !calm && $urandom_range(0, 4) == 0) begin
          tx_gap    <= $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          on_offer = pending_items.pop_front();
          in_tdata  <= {4'b0, on_offer.plane_height, on_offer.plane_width,
                        on_offer.plane_top, on_offer.plane_left, on_offer.plane_id};
          in_tuser  <= on_offer.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with short random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap     <= 0;
      stall_left <= 0;
    end else if (stall_req && !stall_taken) begin
      stall_taken <= 1'b1;
      stall_left  <= LONG_STALL;
      out_tready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap     <= rx_gap - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_gap     <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: each result transfer against the oldest expected report
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (zone_reports_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual zone %0d slot %0d last %0d",
                 $time, out_tdata[3:0], out_tdata[11:4], out_tlast);
        failed = 1'b1;
      end else begin
        taken_report = zone_reports_due.pop_front();
        check_field("zone_index", taken_report.zone, out_tdata[3:0]);
        check_field("slot", taken_report.slot, out_tdata[11:4]);
        check_field("hit", taken_report.hit, out_tuser[0]);
        check_field("overflow", taken_report.ovf, out_tuser[1]);
        check_field("last", taken_report.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("grid_zone_binning regression: fail");
      $finish;
    end
  end

  task automatic queue_item(item_t it);
    pending_items.push_back(it);
    items_queued = items_queued + 1;
  endtask

  // every item accepted and every report seen, then let the block settle
  task automatic wait_drained();
    do @(posedge clk); while (items_taken != items_queued || zone_reports_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) field_w = val;
    else field_h = val;
  endtask

  initial begin
    field_h = SCR_H_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset geometry: 200 by 150 zones
    queue_item(make_clear());
    queue_item(make_insert(8'h00, -4096, -4096, 0, 0));
    queue_item(make_insert(8'hff, 4095, 4095, 511, 511));
    queue_item(make_insert(8'ha5, 0, 0, 0, 0));
    queue_item(make_insert(8'h5a, 200, 150, 0, 0));       // corner on four zones
    queue_item(make_insert(8'h11, 199, 149, 202, 152));
    queue_item(make_insert(8'h22, -100, -100, 100, 100)); // far corner on the origin
    queue_item(make_insert(8'h33, 800, 600, 0, 0));       // bottom right of the field
    queue_item(make_insert(8'h44, -5, 300, 511, 511));
    queue_item(make_clear());
    queue_item(make_insert(8'h55, 10, 10, 5, 5));
    wait_drained();

    write_reg(CFG_SCREEN_WIDTH, 12'd4095);
    write_reg(CFG_SCREEN_HEIGHT, 12'd4095);
    queue_item(make_insert(8'h66, 1023, 1023, 0, 0));
    queue_item(make_insert(8'h77, 3069, 3069, 511, 511));
    queue_item(make_insert(8'h88, -4096, 4095, 511, 0));
    wait_drained();

    // field narrower than the grid: every zone shrinks to the origin
    write_reg(CFG_SCREEN_WIDTH, 12'd1);
    write_reg(CFG_SCREEN_HEIGHT, 12'd3);
    queue_item(make_insert(8'h99, 0, 0, 0, 0));
    queue_item(make_insert(8'haa, -1, 0, 1, 0));
    queue_item(make_insert(8'hbb, 1, 0, 0, 0));
    queue_item(make_clear());
    wait_drained();

    write_reg(CFG_SCREEN_WIDTH, 12'd800);
    write_reg(CFG_SCREEN_HEIGHT, 12'd600);
    for (int i = 0; i < 110; i++) begin
      if ($urandom_range(0, 9) == 0) queue_item(make_clear());
      else if ($urandom_range(0, 1) == 0) queue_item(random_plane());
      else queue_item(make_insert(ID_W'($urandom), $urandom_range(0, 1000) - 100,
                                  $urandom_range(0, 800) - 100,
                                  $urandom_range(0, 511), $urandom_range(0, 511)));
    end
    // hold the result side off while items keep coming
    @(posedge clk);
    stall_req <= 1'b1;
    wait_drained();

    // small field, no clears: the top left zone overruns its list
    write_reg(CFG_SCREEN_WIDTH, 12'd16);
    write_reg(CFG_SCREEN_HEIGHT, 12'd16);
    for (int i = 0; i < 290; i++) begin
      if ($urandom_range(0, 9) == 0) queue_item(random_plane());
      else queue_item(make_insert(ID_W'($urandom), $urandom_range(0, 4), $urandom_range(0, 4),
                                  $urandom_range(0, 12), $urandom_range(0, 12)));
    end
    wait_drained();

    // closing stretch with no idling on either side
    calm <= 1'b1;
    queue_item(make_clear());
    for (int i = 0; i < 20; i++) begin
      if ($urandom_range(0, 7) == 0) queue_item(make_clear());
      else queue_item(make_insert(ID_W'($urandom), $urandom_range(0, 20) - 2,
                                  $urandom_range(0, 20) - 2,
                                  $urandom_range(0, 16), $urandom_range(0, 16)));
    end
    wait_drained();
    repeat (24) @(posedge clk);

    if (!failed && zone_reports_due.size() == 0) begin
      $display("grid_zone_binning regression: pass");
    end else begin
      $display("grid_zone_binning regression: fail");
    end
    $finish;
  end

endmodule
